// ===== hdl/deq_pkg.sv =====
// shared types and constants of the double-ended queue
package deq_pkg;

   localparam int WORD_W = 32;

   // item commands
   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } deq_cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_OVERFLOW  = 2'd1,
      STS_UNDERFLOW = 2'd2
   } deq_status_type;

   // control sequencer
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } deq_state_type;

   typedef logic signed [WORD_W-1:0] deq_word_type;

endpackage

// ===== hdl/deq_if.sv =====
// request and response channel interfaces of the double-ended queue

interface deq_req_if
   import deq_pkg::*;
();
   logic         valid;
   logic         ready;
   deq_cmd_type  command;
   deq_word_type value;

   modport source (output valid, output command, output value, input ready);
   modport sink (input valid, input command, input value, output ready);
endinterface

interface deq_rsp_if
   import deq_pkg::*;
();
   logic           valid;
   logic           ready;
   deq_word_type   popped_value;
   deq_status_type status;
   logic           is_empty;
   logic           is_full;

   modport source (output valid, output popped_value, output status, output is_empty,
                   output is_full, input ready);
   modport sink (input valid, input popped_value, input status, input is_empty,
                 input is_full, output ready);
endinterface

// ===== hdl/double_ended_queue.sv =====
// double-ended queue over a circular buffer, top level
//
// Items carry a command (push front, push rear, pop front, pop rear) and a
// word; each item gives exactly one result with the popped word, a status and
// the empty and full flags after the operation. A push or any failed command
// goes straight to the result register; a successful pop first passes the read
// state, as the entry comes from a single-port-read memory with registered read
// data. The result register frees the input side: a new item is taken while
// the previous result is being handed over. Pushing onto a full queue reports
// overflow and popping an empty queue reports underflow; neither changes state.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_if,
   deq_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W-1:0] IDX_ZERO = '0;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? IDX_ZERO : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
      return (i == IDX_ZERO) ? IDX_LAST : i - 1'b1;
   endfunction

   deq_state_type  state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic           empty_ff, empty_in;

   logic           rsp_valid_ff, rsp_valid_in;
   deq_word_type   rsp_data_ff, rsp_data_in;
   deq_status_type rsp_status_ff, rsp_status_in;
   logic           rsp_empty_ff, rsp_empty_in;
   logic           rsp_full_ff, rsp_full_in;

   logic             accept;
   logic             full;
   logic             is_push;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   deq_word_type     rd_data;

   // storage
   deq_store #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshake
   assign full    = !empty_ff && (idx_inc(tail_ff) == head_ff);
   assign is_push = (req_if.command == CMD_PUSH_FRONT) || (req_if.command == CMD_PUSH_REAR);
   assign accept  = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);

   // command decode, index update and result staging
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      wr_en         = 1'b0;
      wr_addr       = IDX_ZERO;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_status_in = STS_OK;
               rsp_data_in   = '0;
               rsp_valid_in  = 1'b1;
               if (is_push) begin
                  if (full) begin
                     rsp_status_in = STS_OVERFLOW;
                  end else if (empty_ff) begin
                     head_in  = IDX_ZERO;
                     tail_in  = IDX_ZERO;
                     empty_in = 1'b0;
                     wr_en    = 1'b1;
                     wr_addr  = IDX_ZERO;
                  end else if (req_if.command == CMD_PUSH_FRONT) begin
                     head_in = idx_dec(head_ff);
                     wr_en   = 1'b1;
                     wr_addr = idx_dec(head_ff);
                  end else begin
                     tail_in = idx_inc(tail_ff);
                     wr_en   = 1'b1;
                     wr_addr = idx_inc(tail_ff);
                  end
               end else begin
                  if (empty_ff) begin
                     rsp_status_in = STS_UNDERFLOW;
                  end else begin
                     // word arrives from memory next cycle
                     rd_en        = 1'b1;
                     rd_addr      = (req_if.command == CMD_POP_FRONT) ? head_ff : tail_ff;
                     rsp_valid_in = 1'b0;
                     state_in     = ST_READ;
                     if (head_ff == tail_ff) begin
                        head_in  = IDX_ZERO;
                        tail_in  = IDX_ZERO;
                        empty_in = 1'b1;
                     end else if (req_if.command == CMD_POP_FRONT) begin
                        head_in = idx_inc(head_ff);
                     end else begin
                        tail_in = idx_dec(tail_ff);
                     end
                  end
               end
               rsp_empty_in = empty_in;
               rsp_full_in  = !empty_in && (idx_inc(tail_in) == head_in);
            end
         end
         ST_READ: begin
            rsp_data_in  = rd_data;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= IDX_ZERO;
         tail_ff      <= IDX_ZERO;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.popped_value = rsp_data_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.is_empty     = rsp_empty_ff;
   assign rsp_if.is_full      = rsp_full_ff;

`ifndef SYNTHESIS
   // a pop from a non-empty queue waits for the memory read
   a_pop_reads: assert property (@(posedge clock) disable iff (reset)
      accept && !is_push && !empty_ff |=> state_ff == ST_READ)
      else $error("pop did not enter memory read");

   // no result is shown while its word is still in flight
   a_read_no_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("result valid during memory read");

   // an empty queue keeps both indices at zero
   a_empty_idx: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == IDX_ZERO) && (tail_ff == IDX_ZERO))
      else $error("empty queue with nonzero index");

   // failed commands return a zero word
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STS_OK) |-> rsp_data_ff == '0)
      else $error("error result with nonzero word");

   // a memory write and read never share a cycle
   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("simultaneous memory read and write");
`endif

endmodule

// ===== hdl/deq_store.sv =====
// entry storage: one write port, one read port with registered read data
module deq_store
   import deq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  deq_word_type     wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output deq_word_type     rd_data
);

   deq_word_type mem [DEPTH];
   deq_word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
